FILE: hdl/aob_pkg.sv
package aob_pkg;

   localparam int CHAN_W = 8;
   localparam int LANES = 3;
   localparam int PROD_W = 2 * CHAN_W;
   localparam int WIDE_W = 3 * CHAN_W;
   localparam int NUM_W = PROD_W + 1;

   localparam int LANE_RED = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE = 2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

   // floor(x / 255) as floor(x * ceil(2^32 / 255) / 2^32), exact for x <= 255^3
   localparam int RECIP_W = 25;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;
   localparam int PRODUCT_W = WIDE_W + RECIP_W;

   localparam int PRE_STAGES = 4;
   localparam int DIV_STAGES = CHAN_W;
   localparam int RESULT_DELAY = PRE_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_alpha;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_alpha;
   } rsp_word_type;

   typedef struct packed {
      logic                         valid;
      logic [CHAN_W-1:0]            alpha;
      logic [LANES-1:0]             sat;
      logic [LANES-1:0][NUM_W-1:0]  num;
   } div_word_type;

   function automatic logic [PROD_W-1:0] div255(input logic [WIDE_W-1:0] value);
      logic [PRODUCT_W-1:0] product;
      product = PRODUCT_W'(value) * PRODUCT_W'(RECIP_255);
      return product[RECIP_SHIFT+PROD_W-1:RECIP_SHIFT];
   endfunction

endpackage

FILE: hdl/aob_divider.sv
module aob_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  aob_pkg::div_word_type div_word,
   output logic                  result_valid,
   output aob_pkg::rsp_word_type result_word
);

   typedef struct packed {
      logic                                            valid;
      logic [aob_pkg::CHAN_W-1:0]                      alpha;
      logic [aob_pkg::LANES-1:0]                       sat;
      logic [aob_pkg::LANES-1:0][aob_pkg::NUM_W-1:0]   rem;
      logic [aob_pkg::LANES-1:0][aob_pkg::CHAN_W-1:0]  quo;
   } step_type;

   step_type stage_src [aob_pkg::DIV_STAGES];
   step_type stage_in  [aob_pkg::DIV_STAGES];
   step_type stage_ff  [aob_pkg::DIV_STAGES];
   step_type last;
   logic [aob_pkg::LANES-1:0][aob_pkg::CHAN_W-1:0] chan;

   for (genvar k = 0; k < aob_pkg::DIV_STAGES; k++) begin : g_step
      localparam int Bit = aob_pkg::DIV_STAGES - 1 - k;
      logic [aob_pkg::NUM_W-1:0] shifted;

      if (k > 0) begin : g_link
         assign stage_src[k] = stage_ff[k-1];
      end else begin : g_head
         assign stage_src[k] = '{valid: div_word.valid, alpha: div_word.alpha,
                                 sat: div_word.sat, rem: div_word.num, quo: '0};
      end

      // one restoring step: one quotient bit per stage
      assign shifted = aob_pkg::NUM_W'(stage_src[k].alpha) << Bit;

      always_comb begin
         stage_in[k] = stage_src[k];
         for (int l = 0; l < aob_pkg::LANES; l++) begin
            if (stage_src[k].rem[l] >= shifted) begin
               stage_in[k].rem[l] = stage_src[k].rem[l] - shifted;
               stage_in[k].quo[l][Bit] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < aob_pkg::DIV_STAGES; k++) begin
         stage_ff[k].alpha <= stage_in[k].alpha;
         stage_ff[k].sat <= stage_in[k].sat;
         stage_ff[k].rem <= stage_in[k].rem;
         stage_ff[k].quo <= stage_in[k].quo;
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k].valid <= stage_in[k].valid;
         end
      end
   end

   assign last = stage_ff[aob_pkg::DIV_STAGES-1];

   always_comb begin
      for (int l = 0; l < aob_pkg::LANES; l++) begin
         if (last.alpha == aob_pkg::CHAN_ZERO) begin
            chan[l] = aob_pkg::CHAN_ZERO;
         end else if (last.sat[l]) begin
            chan[l] = aob_pkg::CHAN_MAX;
         end else begin
            chan[l] = last.quo[l];
         end
      end
   end

   assign result_valid = last.valid;
   assign result_word.out_red = chan[aob_pkg::LANE_RED];
   assign result_word.out_green = chan[aob_pkg::LANE_GREEN];
   assign result_word.out_blue = chan[aob_pkg::LANE_BLUE];
   assign result_word.out_alpha = last.alpha;

endmodule

FILE: hdl/alpha_over_blend.sv
// Composites a straight-alpha source pixel over a destination pixel, one pixel per clock.
// A word is taken whenever start is high; busy is always low, so a new word may follow in
// every cycle. Each result shows on rsp_word for one cycle with rsp_strobe high, in order,
// after four arithmetic stages (products, the divides by 255, the numerator sum), an
// eight-stage restoring divider that settles one quotient bit per stage, and the output
// register. The receiver has no way to stall.
module alpha_over_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  aob_pkg::req_word_type req_word,
   output logic                  busy,
   output logic                  rsp_strobe,
   output aob_pkg::rsp_word_type rsp_word
);

   localparam int CW = aob_pkg::CHAN_W;
   localparam int PW = aob_pkg::PROD_W;
   localparam int WW = aob_pkg::WIDE_W;
   localparam int NW = aob_pkg::NUM_W;
   localparam int LN = aob_pkg::LANES;

   logic accept;
   logic [LN-1:0][CW-1:0] src_chan;
   logic [LN-1:0][CW-1:0] dst_chan;

   logic              inv_in;
   logic [CW-1:0]     s1_inv_in;
   logic [PW-1:0]     s1_ta_in;
   logic [LN-1:0][PW-1:0] s1_ps_in;
   logic [LN-1:0][PW-1:0] s1_dd_in;

   logic              s1_valid_ff;
   logic [CW-1:0]     s1_inv_ff;
   logic [CW-1:0]     s1_sa_ff;
   logic [PW-1:0]     s1_ta_ff;
   logic [LN-1:0][PW-1:0] s1_ps_ff;
   logic [LN-1:0][PW-1:0] s1_dd_ff;

   logic [CW-1:0]     s2_alpha_in;
   logic [LN-1:0][WW-1:0] s2_pdx_in;
   logic              s2_valid_ff;
   logic [CW-1:0]     s2_alpha_ff;
   logic [LN-1:0][PW-1:0] s2_ps_ff;
   logic [LN-1:0][WW-1:0] s2_pdx_ff;

   logic [LN-1:0][PW-1:0] s3_pd_in;
   logic              s3_valid_ff;
   logic [CW-1:0]     s3_alpha_ff;
   logic [LN-1:0][PW-1:0] s3_ps_ff;
   logic [LN-1:0][PW-1:0] s3_pd_ff;

   aob_pkg::div_word_type div_in;
   aob_pkg::div_word_type div_ff;

   logic                  div_valid;
   aob_pkg::rsp_word_type div_word;
   logic                  rsp_strobe_ff;
   aob_pkg::rsp_word_type rsp_word_ff;

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign inv_in = accept;

   assign src_chan = {req_word.src_blue, req_word.src_green, req_word.src_red};
   assign dst_chan = {req_word.dst_blue, req_word.dst_green, req_word.dst_red};

   // stage 1: products
   always_comb begin
      s1_inv_in = aob_pkg::CHAN_MAX - req_word.src_alpha;
      s1_ta_in = PW'(req_word.dst_alpha) * PW'(s1_inv_in);
      for (int l = 0; l < LN; l++) begin
         s1_ps_in[l] = PW'(src_chan[l]) * PW'(req_word.src_alpha);
         s1_dd_in[l] = PW'(dst_chan[l]) * PW'(req_word.dst_alpha);
      end
   end

   // stage 2: combined alpha, destination term scaled by source transparency
   always_comb begin
      s2_alpha_in = s1_sa_ff + CW'(aob_pkg::div255(WW'(s1_ta_ff)));
      for (int l = 0; l < LN; l++) begin
         s2_pdx_in[l] = WW'(s1_dd_ff[l]) * WW'(s1_inv_ff);
      end
   end

   // stage 3: destination term over 255
   always_comb begin
      for (int l = 0; l < LN; l++) begin
         s3_pd_in[l] = aob_pkg::div255(s2_pdx_ff[l]);
      end
   end

   // stage 4: numerator and overflow check against alpha * 256
   always_comb begin
      div_in.valid = s3_valid_ff;
      div_in.alpha = s3_alpha_ff;
      for (int l = 0; l < LN; l++) begin
         div_in.num[l] = NW'(s3_ps_ff[l]) + NW'(s3_pd_ff[l]);
         div_in.sat[l] = div_in.num[l] >= {1'b0, s3_alpha_ff, {CW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      div_ff.alpha <= div_in.alpha;
      div_ff.sat <= div_in.sat;
      div_ff.num <= div_in.num;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         div_ff.valid <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff <= inv_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         div_ff.valid <= div_in.valid;
         rsp_strobe_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_inv_ff <= s1_inv_in;
      s1_sa_ff <= req_word.src_alpha;
      s1_ta_ff <= s1_ta_in;
      s1_ps_ff <= s1_ps_in;
      s1_dd_ff <= s1_dd_in;
      s2_alpha_ff <= s2_alpha_in;
      s2_ps_ff <= s1_ps_ff;
      s2_pdx_ff <= s2_pdx_in;
      s3_alpha_ff <= s2_alpha_ff;
      s3_ps_ff <= s2_ps_ff;
      s3_pd_ff <= s3_pd_in;
      rsp_word_ff <= div_word;
   end

   aob_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_word     (div_ff),
      .result_valid (div_valid),
      .result_word  (div_word)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word = rsp_word_ff;

endmodule

FILE: hdl/aob_checker.sv
module aob_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input aob_pkg::req_word_type req_word,
   input logic                  busy,
   input logic                  rsp_strobe,
   input aob_pkg::rsp_word_type rsp_word
);

   localparam int Delay = aob_pkg::RESULT_DELAY;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##Delay rsp_strobe)
      else $error("word not answered at fixed latency");

   a_no_stray_result : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, Delay))
      else $error("result without a started word");

   a_transparent_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.out_alpha == aob_pkg::CHAN_ZERO |->
         rsp_word.out_red == aob_pkg::CHAN_ZERO && rsp_word.out_green == aob_pkg::CHAN_ZERO
         && rsp_word.out_blue == aob_pkg::CHAN_ZERO)
      else $error("transparent result with color");

   a_opaque_source : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.src_alpha == aob_pkg::CHAN_MAX |-> ##Delay
         rsp_word.out_alpha == aob_pkg::CHAN_MAX
         && rsp_word.out_red == $past(req_word.src_red, Delay)
         && rsp_word.out_green == $past(req_word.src_green, Delay)
         && rsp_word.out_blue == $past(req_word.src_blue, Delay))
      else $error("opaque source not passed through");

endmodule

bind alpha_over_blend aob_checker u_aob_checker (.*);
